@@ hw/rtl/ffrag_pkg.sv @@
// shared types and constants of the frame fragmenter
package ffrag_pkg;

    // sizes of the datapath
    localparam int unsigned FRAME_MAX  = 4096;
    localparam int unsigned PACKET_MAX = 64;

    localparam logic [12:0] FRAME_MAX_LEN   = 13'(FRAME_MAX);
    localparam logic [6:0]  PACKET_MAX_SIZE = 7'(PACKET_MAX);
    localparam logic [6:0]  PACKET_MIN_SIZE = 7'd3;

    // header byte fields
    localparam logic [7:0] FRAG_MASK = 8'h7F;
    localparam logic [7:0] LAST_FLAG = 8'h80;

    // configuration register indexes
    localparam logic CFG_LINK_MODE    = 1'b0;
    localparam logic CFG_PACKET_BYTES = 1'b1;

    // link mode codes
    localparam logic [1:0] MODE_PADDED   = 2'd1;
    localparam logic [1:0] MODE_VARIABLE = 2'd2;

    // which byte the datapath puts into the output register
    typedef enum logic [1:0] {
        SEL_SEQ  = 2'd0,
        SEL_FRAG = 2'd1,
        SEL_DATA = 2'd2,
        SEL_PAD  = 2'd3
    } emit_sel_t;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      out_load;
        emit_sel_t sel;
        logic      pad_dec;
    } ffrag_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hdr_now;
        logic out_free;
        logic pad_zero;
        logic pad_one;
    } ffrag_status_t;

endpackage

@@ hw/rtl/frame_fragmenter.sv @@
// top level of the frame fragmenter: byte stream in, sequenced packets out
// a byte is taken when idle; its results (sequence byte, fragment header, data,
// padding) go into the single output register in that order, one byte a cycle while
// it is free, and the next byte is taken once the run's last result is loaded;
// n results per byte (1 or 3 usually, up to 64 with padding)
// reset: synchronous active low; link off, packet size 32, no frame open, sequence 0
module frame_fragmenter (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], frame_length[20:8], zero[23:21]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,   // run_last
    output logic [1:0]  m_tuser,   // packet_last[0], dropped[1]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    import ffrag_pkg::*;

    ffrag_cmd_t    cmd;
    ffrag_status_t status;
    logic          packet_last;
    logic          dropped;

    assign cfg_ready = 1'b1;

    ffrag_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffrag_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_byte    (s_tdata[7:0]),
        .frame_length (s_tdata[20:8]),
        .cmd          (cmd),
        .status       (status),
        .m_tready     (m_tready),
        .out_valid    (m_tvalid),
        .out_byte     (m_tdata),
        .packet_last  (packet_last),
        .run_last     (m_tlast),
        .dropped      (dropped)
    );

    assign m_tuser = {dropped, packet_last};

    // a transaction keeps the block busy: it is not ready in the cycle after it takes a byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // a dropped byte is a single result that ends its run and no packet
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
        else $error("malformed drop result");

    // going back to idle means the last result of the run was just loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready ##1 s_tready |-> m_tvalid && m_tlast)
        else $error("idle without run end");

endmodule

@@ hw/rtl/ffrag_datapath.sv @@
// datapath: configuration, frame state, per-transaction plan and output register
module ffrag_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [6:0]             cfg_data,
    input  logic [7:0]             data_byte,
    input  logic [12:0]            frame_length,
    input  ffrag_pkg::ffrag_cmd_t  cmd,
    output ffrag_pkg::ffrag_status_t status,
    input  logic                   m_tready,
    output logic                   out_valid,
    output logic [7:0]             out_byte,
    output logic                   packet_last,
    output logic                   run_last,
    output logic                   dropped
);
    import ffrag_pkg::*;

    // configuration
    logic [1:0]  link_mode_reg;
    logic [6:0]  packet_bytes_reg;

    // frame state
    logic [7:0]  seq_reg,  seq_next;
    logic [12:0] rem_reg,  rem_next;
    logic [6:0]  frag_reg, frag_next;
    logic [5:0]  fill_reg, fill_next;

    // plan of the accepted transaction
    logic [7:0]  seq_byte_reg;
    logic [7:0]  hdr_reg,  hdr_next;
    logic [7:0]  data_reg;
    logic        plast_reg, plast_next;
    logic        drop_reg;
    logic [5:0]  pad_reg,  pad_next;

    // output register
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg,  out_byte_next;
    logic        out_plast_reg, out_plast_next;
    logic        out_rlast_reg, out_rlast_next;
    logic        out_drop_reg,  out_drop_next;

    // step arithmetic
    logic [6:0]  psize;
    logic [5:0]  body;
    logic        drop_now;
    logic [12:0] flen;
    logic [12:0] rem_eff;
    logic [6:0]  frag_eff;
    logic [5:0]  fill_raw;
    logic [5:0]  fill_eff;
    logic [12:0] rem_dec;
    logic [5:0]  fill_inc;
    logic        pkt_end;
    logic        frame_end;

    always_comb begin
        // clamp packet size, body is what is left after the header
        if (packet_bytes_reg < PACKET_MIN_SIZE) begin
            psize = PACKET_MIN_SIZE;
        end else if (packet_bytes_reg > PACKET_MAX_SIZE) begin
            psize = PACKET_MAX_SIZE;
        end else begin
            psize = packet_bytes_reg;
        end
        body = 6'(psize - 7'd2);

        drop_now = !(link_mode_reg == MODE_PADDED || link_mode_reg == MODE_VARIABLE);

        // frame length of a new frame
        if (frame_length == 13'd0) begin
            flen = 13'd1;
        end else if (frame_length > FRAME_MAX_LEN) begin
            flen = FRAME_MAX_LEN;
        end else begin
            flen = frame_length;
        end

        // open a frame when none is open
        if (rem_reg == 13'd0) begin
            rem_eff  = flen;
            frag_eff = 7'd0;
            fill_raw = 6'd0;
        end else begin
            rem_eff  = rem_reg;
            frag_eff = frag_reg;
            fill_raw = fill_reg;
        end
        fill_eff = (fill_raw >= body) ? 6'd0 : fill_raw;

        hdr_next = ({1'b0, frag_eff} & FRAG_MASK)
                 | ((rem_eff <= {7'd0, body}) ? LAST_FLAG : 8'h00);

        rem_dec   = rem_eff - 13'd1;
        fill_inc  = fill_eff + 6'd1;
        pkt_end   = (fill_inc >= body);
        frame_end = (rem_dec == 13'd0);

        // default: byte in the middle of a packet
        seq_next   = seq_reg;
        rem_next   = rem_dec;
        frag_next  = frag_eff;
        fill_next  = fill_inc;
        plast_next = 1'b0;
        pad_next   = 6'd0;

        if (drop_now) begin
            // abandon any open frame, its sequence number is spent
            seq_next  = (rem_reg != 13'd0) ? seq_reg + 8'd1 : seq_reg;
            rem_next  = 13'd0;
            frag_next = 7'd0;
            fill_next = 6'd0;
        end else begin
            if (pkt_end) begin
                plast_next = 1'b1;
                fill_next  = 6'd0;
                frag_next  = frag_eff + 7'd1;
            end else if (frame_end) begin
                if (link_mode_reg == MODE_PADDED) begin
                    pad_next = body - fill_inc;
                end else begin
                    plast_next = 1'b1;
                end
                fill_next = 6'd0;
            end
            if (frame_end) begin
                seq_next  = seq_reg + 8'd1;
                frag_next = 7'd0;
                fill_next = 6'd0;
            end
        end
    end

    // configuration writes and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_mode_reg    <= 2'd0;
            packet_bytes_reg <= 7'd32;
            seq_reg          <= 8'd0;
            rem_reg          <= 13'd0;
            frag_reg         <= 7'd0;
            fill_reg         <= 6'd0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_LINK_MODE:    link_mode_reg    <= cfg_data[1:0];
                    CFG_PACKET_BYTES: packet_bytes_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.load) begin
                seq_reg  <= seq_next;
                rem_reg  <= rem_next;
                frag_reg <= frag_next;
                fill_reg <= fill_next;
            end
        end
    end

    // plan of the transaction, old sequence number goes into the header
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_reg <= 1'b0;
            pad_reg  <= 6'd0;
        end else if (cmd.load) begin
            drop_reg <= drop_now;
            pad_reg  <= pad_next;
        end else if (cmd.pad_dec) begin
            pad_reg <= pad_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            seq_byte_reg <= seq_reg;
            hdr_reg      <= hdr_next;
            data_reg     <= data_byte;
            plast_reg    <= plast_next;
        end
    end

    // output byte selection
    always_comb begin
        out_byte_next  = 8'h00;
        out_plast_next = 1'b0;
        out_rlast_next = 1'b0;
        out_drop_next  = 1'b0;
        case (cmd.sel)
            SEL_SEQ:  out_byte_next = seq_byte_reg;
            SEL_FRAG: out_byte_next = hdr_reg;
            SEL_DATA: begin
                out_byte_next  = drop_reg ? 8'h00 : data_reg;
                out_plast_next = plast_reg && !drop_reg;
                out_rlast_next = (pad_reg == 6'd0);
                out_drop_next  = drop_reg;
            end
            SEL_PAD: begin
                out_plast_next = (pad_reg == 6'd1);
                out_rlast_next = (pad_reg == 6'd1);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_byte_reg  <= out_byte_next;
            out_plast_reg <= out_plast_next;
            out_rlast_reg <= out_rlast_next;
            out_drop_reg  <= out_drop_next;
        end
    end

    assign status.hdr_now  = !drop_now && (fill_eff == 6'd0);
    assign status.out_free = !out_valid_reg || m_tready;
    assign status.pad_zero = (pad_reg == 6'd0);
    assign status.pad_one  = (pad_reg == 6'd1);

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign packet_last = out_plast_reg;
    assign run_last    = out_rlast_reg;
    assign dropped     = out_drop_reg;

endmodule

@@ hw/rtl/ffrag_ctrl.sv @@
// controller: sequences header, data and padding bytes of one transaction
module ffrag_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  ffrag_pkg::ffrag_status_t status,
    output ffrag_pkg::ffrag_cmd_t    cmd
);
    import ffrag_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SEQ  = 5'b00010,
        ST_FRAG = 5'b00100,
        ST_DATA = 5'b01000,
        ST_PAD  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.out_load = 1'b0;
        cmd.sel      = SEL_DATA;
        cmd.pad_dec  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = status.hdr_now ? ST_SEQ : ST_DATA;
                end
            end
            ST_SEQ: begin
                cmd.sel = SEL_SEQ;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_FRAG;
                end
            end
            ST_FRAG: begin
                cmd.sel = SEL_FRAG;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_DATA;
                end
            end
            ST_DATA: begin
                cmd.sel = SEL_DATA;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = status.pad_zero ? ST_IDLE : ST_PAD;
                end
            end
            ST_PAD: begin
                cmd.sel = SEL_PAD;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.pad_dec  = 1'b1;
                    if (status.pad_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
